[rtl/core/cds_pkg.sv]
// Shared types, widths and codes for the critically damped smoother.
package cds_pkg;

    // Field widths
    localparam int DATA_W  = 32;
    localparam int UDATA_W = 31;
    localparam int CFG_W   = 31;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_TIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 1'd1;

    // Saturation limits
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // Sequencer steps: two divisions and a chain of products on one multiplier
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_OMEGA,
        ST_M_X,
        ST_M_X2,
        ST_M_D2,
        ST_M_X3,
        ST_M_D3,
        ST_DIV_E,
        ST_M_MAXC,
        ST_M_A1,
        ST_M_TMP,
        ST_M_A2,
        ST_M_NV,
        ST_M_P,
        ST_DONE
    } cds_state_t;

    // Saturating 32-bit add or subtract
    function automatic logic signed [DATA_W-1:0] sat_sum(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        input logic                     neg
    );
        logic signed [DATA_W:0] ax;
        logic signed [DATA_W:0] bx;
        logic signed [DATA_W:0] s;
        ax = $signed({a[DATA_W-1], a});
        bx = $signed({b[DATA_W-1], b});
        s  = neg ? (ax - bx) : (ax + bx);
        if (s > $signed({Q_MAX[DATA_W-1], Q_MAX}))
            return Q_MAX;
        else if (s < $signed({Q_MIN[DATA_W-1], Q_MIN}))
            return Q_MIN;
        else
            return s[DATA_W-1:0];
    endfunction

endpackage

[rtl/core/cds_item_if.sv]
// Input channel: current position, target and time step.
interface cds_item_if import cds_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  current_pos;
    logic signed [DATA_W-1:0]  target_pos;
    logic        [UDATA_W-1:0] time_step;

    modport source (output valid, current_pos, target_pos, time_step, input ready);
    modport sink   (input valid, current_pos, target_pos, time_step, output ready);
endinterface

[rtl/core/cds_result_if.sv]
// Output channel: smoothed position, new velocity and snap flag.
interface cds_result_if import cds_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] new_pos;
    logic signed [DATA_W-1:0] new_velocity;
    logic                     snapped;

    modport source (output valid, new_pos, new_velocity, snapped, input ready);
    modport sink   (input valid, new_pos, new_velocity, snapped, output ready);
endinterface

[rtl/core/critically_damped_smoother_top.sv]
// Critically damped spring smoother: sequencer, shared multiplier and shared divider.
//
// Usage:
//   item   : valid/ready channel carrying current_pos, target_pos, time_step.
//   result : valid/ready channel carrying new_pos, new_velocity, snapped.
//   cfg    : write port; cfg_index 0 writes smooth_time, 1 writes max_speed.
//            Write only while the block is idle.
// Timing:
//   One transaction at a time. An item runs two divisions on the divider
//   (one quotient bit per cycle) and eleven products on the single 32x32
//   multiplier, then a finish step that loads the result register.
// Reset:
//   Velocity clears to zero, smooth_time to 1.0, max_speed to full scale,
//   and no result is pending.
// Stall:
//   A finished result sits in the output register until taken; the next item
//   can be accepted meanwhile, and its result waits until the register frees.
module critically_damped_smoother_top
    import cds_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    cds_item_if.sink             item,
    cds_result_if.source         result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Derived constants
    localparam longint ONE_L    = longint'(1) << FRAC_BITS;
    localparam longint C48_L    = (48 * ONE_L + 50) / 100;
    localparam longint C235_L   = (235 * ONE_L + 500) / 1000;
    localparam longint MIN_RAW  = (ONE_L + 5000) / 10000;
    localparam longint MIN_ST_L = (MIN_RAW < 1) ? 1 : MIN_RAW;
    localparam logic signed [DATA_W-1:0] ONE_Q  = DATA_W'(ONE_L);
    localparam logic signed [DATA_W-1:0] C48_Q  = DATA_W'(C48_L);
    localparam logic signed [DATA_W-1:0] C235_Q = DATA_W'(C235_L);
    localparam logic [CFG_W-1:0]         MIN_ST = CFG_W'(MIN_ST_L);
    localparam logic signed [2*DATA_W:0] HALF_Q = 65'sd1 <<< (FRAC_BITS - 1);
    localparam int NUM_W = 2 * FRAC_BITS + 2;
    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_TOP     = CNT_W'(NUM_W - 1);
    localparam logic [CNT_W-1:0] POS_OMEGA   = CNT_W'(2 * FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] POS_E       = CNT_W'(2 * FRAC_BITS);

    // Control state
    cds_state_t state_reg, state_next;
    logic       phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic [CFG_W-1:0] smooth_time_reg, smooth_time_next;
    logic [CFG_W-1:0] max_speed_reg, max_speed_next;
    logic signed [DATA_W-1:0] vel_reg, vel_next;

    // Datapath registers
    logic signed [DATA_W-1:0]  c_reg, c_next;
    logic signed [DATA_W-1:0]  t_reg, t_next;
    logic        [UDATA_W-1:0] dt_reg, dt_next;
    logic        [CFG_W-1:0]   st_reg, st_next;
    logic signed [DATA_W-1:0]  omega_reg, omega_next;
    logic signed [DATA_W-1:0]  e_reg, e_next;
    logic signed [DATA_W-1:0]  x_reg, x_next;
    logic signed [DATA_W-1:0]  x2_reg, x2_next;
    logic signed [DATA_W-1:0]  den_reg, den_next;
    logic signed [DATA_W-1:0]  ch_reg, ch_next;
    logic signed [DATA_W-1:0]  tmp_reg, tmp_next;
    logic signed [DATA_W-1:0]  nv_reg, nv_next;
    logic signed [DATA_W-1:0]  p_reg, p_next;
    logic signed [2*DATA_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]  q_reg, q_next;
    logic signed [DATA_W-1:0] res_pos_reg, res_pos_next;
    logic signed [DATA_W-1:0] res_vel_reg, res_vel_next;
    logic                     res_snap_reg, res_snap_next;

    // Shared unit wiring
    logic signed [DATA_W-1:0]   mul_a, mul_b;
    logic signed [2*DATA_W:0]   rnd_sum, rnd_shift;
    logic signed [DATA_W-1:0]   mul_res;
    logic [DATA_W-1:0]          div_d;
    logic                       num_bit;
    logic [DATA_W:0]            r_sh;
    logic                       div_ge;
    logic [NUM_W-1:0]           q_step;
    logic [2*DATA_W-1:0]        q_wide;
    logic signed [DATA_W-1:0]   div_res;
    logic signed [DATA_W-1:0]   maxc_neg, ch_clamp;
    logic                       snap;
    logic                       load_out;

    assign item.ready          = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.new_pos      = res_pos_reg;
    assign result.new_velocity = res_vel_reg;
    assign result.snapped      = res_snap_reg;

    // Multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_M_X:    begin mul_a = omega_reg; mul_b = $signed({1'b0, dt_reg}); end
            ST_M_X2:   begin mul_a = x_reg;     mul_b = x_reg;                   end
            ST_M_D2:   begin mul_a = C48_Q;     mul_b = x2_reg;                  end
            ST_M_X3:   begin mul_a = x2_reg;    mul_b = x_reg;                   end
            ST_M_D3:   begin mul_a = C235_Q;    mul_b = x2_reg;                  end
            ST_M_MAXC: begin
                mul_a = $signed({1'b0, max_speed_reg});
                mul_b = $signed({1'b0, st_reg});
            end
            ST_M_A1:   begin mul_a = omega_reg; mul_b = ch_reg;                  end
            ST_M_TMP:  begin mul_a = tmp_reg;   mul_b = $signed({1'b0, dt_reg}); end
            ST_M_A2:   begin mul_a = omega_reg; mul_b = tmp_reg;                 end
            ST_M_NV:   begin mul_a = nv_reg;    mul_b = e_reg;                   end
            ST_M_P:    begin mul_a = ch_reg;    mul_b = e_reg;                   end
            default:   begin mul_a = '0;        mul_b = '0;                      end
        endcase
    end

    // Product rounding (ties toward +inf) and saturation
    always_comb
    begin
        prod_next = mul_a * mul_b;
        rnd_sum   = $signed({prod_reg[2*DATA_W-1], prod_reg}) + HALF_Q;
        rnd_shift = rnd_sum >>> FRAC_BITS;
        if (rnd_shift > 65'sd2147483647)
            mul_res = Q_MAX;
        else if (rnd_shift < -65'sd2147483648)
            mul_res = Q_MIN;
        else
            mul_res = rnd_shift[DATA_W-1:0];
    end

    // Restoring divider step: constant power-of-two dividend, one bit per cycle
    always_comb
    begin
        div_d   = (state_reg == ST_DIV_OMEGA) ? {1'b0, st_reg} : den_reg;
        num_bit = (state_reg == ST_DIV_OMEGA) ? (cnt_reg == POS_OMEGA)
                                              : (cnt_reg == POS_E);
        r_sh    = {rem_reg, num_bit};
        div_ge  = (r_sh >= {1'b0, div_d});
        q_step  = {q_reg[NUM_W-2:0], div_ge};
        q_wide  = (2*DATA_W)'(q_step);
        if (q_wide > 64'h7FFF_FFFF)
            div_res = Q_MAX;
        else
            div_res = q_wide[DATA_W-1:0];
    end

    // Clamp of the distance and overshoot test
    always_comb
    begin
        maxc_neg = -mul_res;
        if (ch_reg > mul_res)
            ch_clamp = mul_res;
        else if (ch_reg < maxc_neg)
            ch_clamp = maxc_neg;
        else
            ch_clamp = ch_reg;
        snap     = ((t_reg > c_reg) == (p_reg > t_reg));
        load_out = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        cnt_next         = cnt_reg;
        smooth_time_next = smooth_time_reg;
        max_speed_next   = max_speed_reg;
        vel_next         = vel_reg;
        c_next           = c_reg;
        t_next           = t_reg;
        dt_next          = dt_reg;
        st_next          = st_reg;
        omega_next       = omega_reg;
        e_next           = e_reg;
        x_next           = x_reg;
        x2_next          = x2_reg;
        den_next         = den_reg;
        ch_next          = ch_reg;
        tmp_next         = tmp_reg;
        nv_next          = nv_reg;
        p_next           = p_reg;
        rem_next         = rem_reg;
        q_next           = q_reg;
        res_pos_next     = res_pos_reg;
        res_vel_next     = res_vel_reg;
        res_snap_next    = res_snap_reg;
        out_valid_next   = out_valid_reg && !result.ready;

        // Configuration writes
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SMOOTH_TIME: smooth_time_next = cfg_data;
                REG_MAX_SPEED:   max_speed_next   = cfg_data;
                default:         ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    c_next     = item.current_pos;
                    t_next     = item.target_pos;
                    dt_next    = item.time_step;
                    st_next    = (smooth_time_reg < MIN_ST) ? MIN_ST : smooth_time_reg;
                    ch_next    = sat_sum(item.current_pos, item.target_pos, 1'b1);
                    rem_next   = '0;
                    q_next     = '0;
                    cnt_next   = CNT_TOP;
                    state_next = ST_DIV_OMEGA;
                end
            end
            ST_DIV_OMEGA, ST_DIV_E:
            begin
                rem_next = div_ge ? r_sh[DATA_W-1:0] - div_d : r_sh[DATA_W-1:0];
                q_next   = q_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    phase_next = 1'b0;
                    if (state_reg == ST_DIV_OMEGA)
                    begin
                        omega_next = div_res;
                        state_next = ST_M_X;
                    end
                    else
                    begin
                        e_next     = div_res;
                        state_next = ST_M_MAXC;
                    end
                end
            end
            ST_M_X, ST_M_X2, ST_M_D2, ST_M_X3, ST_M_D3,
            ST_M_MAXC, ST_M_A1, ST_M_TMP, ST_M_A2, ST_M_NV, ST_M_P:
            begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    unique case (state_reg)
                        ST_M_X:
                        begin
                            x_next     = mul_res;
                            den_next   = sat_sum(ONE_Q, mul_res, 1'b0);
                            state_next = ST_M_X2;
                        end
                        ST_M_X2:
                        begin
                            x2_next    = mul_res;
                            state_next = ST_M_D2;
                        end
                        ST_M_D2:
                        begin
                            den_next   = sat_sum(den_reg, mul_res, 1'b0);
                            state_next = ST_M_X3;
                        end
                        ST_M_X3:
                        begin
                            x2_next    = mul_res;
                            state_next = ST_M_D3;
                        end
                        ST_M_D3:
                        begin
                            den_next   = sat_sum(den_reg, mul_res, 1'b0);
                            rem_next   = '0;
                            q_next     = '0;
                            cnt_next   = CNT_TOP;
                            state_next = ST_DIV_E;
                        end
                        ST_M_MAXC:
                        begin
                            ch_next    = ch_clamp;
                            p_next     = sat_sum(c_reg, ch_clamp, 1'b1);
                            state_next = ST_M_A1;
                        end
                        ST_M_A1:
                        begin
                            tmp_next   = sat_sum(vel_reg, mul_res, 1'b0);
                            state_next = ST_M_TMP;
                        end
                        ST_M_TMP:
                        begin
                            tmp_next   = mul_res;
                            state_next = ST_M_A2;
                        end
                        ST_M_A2:
                        begin
                            nv_next    = sat_sum(vel_reg, mul_res, 1'b1);
                            state_next = ST_M_NV;
                        end
                        ST_M_NV:
                        begin
                            nv_next    = mul_res;
                            ch_next    = sat_sum(ch_reg, tmp_reg, 1'b0);
                            state_next = ST_M_P;
                        end
                        ST_M_P:
                        begin
                            p_next     = sat_sum(p_reg, mul_res, 1'b0);
                            state_next = ST_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    res_pos_next   = snap ? t_reg : p_reg;
                    res_vel_next   = snap ? '0 : nv_reg;
                    res_snap_next  = snap;
                    vel_next       = snap ? '0 : nv_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            smooth_time_reg <= CFG_W'(ONE_L);
            max_speed_reg   <= '1;
            vel_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            smooth_time_reg <= smooth_time_next;
            max_speed_reg   <= max_speed_next;
            vel_reg         <= vel_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        c_reg        <= c_next;
        t_reg        <= t_next;
        dt_reg       <= dt_next;
        st_reg       <= st_next;
        omega_reg    <= omega_next;
        e_reg        <= e_next;
        x_reg        <= x_next;
        x2_reg       <= x2_next;
        den_reg      <= den_next;
        ch_reg       <= ch_next;
        tmp_reg      <= tmp_next;
        nv_reg       <= nv_next;
        p_reg        <= p_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        res_pos_reg  <= res_pos_next;
        res_vel_reg  <= res_vel_next;
        res_snap_reg <= res_snap_next;
    end

`ifndef SYNTHESIS
    // An accepted item always starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> (state_reg == ST_DIV_OMEGA))
        else $error("sequencer did not start after accept");

    // Divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_OMEGA || state_reg == ST_DIV_E) |-> (rem_reg < div_d))
        else $error("divider remainder out of range");

    // A snapped result carries zero velocity
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.snapped) |-> (result.new_velocity == '0))
        else $error("snapped result with nonzero velocity");

    // Stored velocity only changes when a result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(vel_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("velocity changed outside result load");
`endif

endmodule
